/* rtl/core/fcct_pkg.sv */
package fcct_pkg;

   localparam int TABLE_DEPTH = 4096;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CLUSTER_W   = 16;
   localparam int COUNT_W     = 12;
   localparam int STEP_W      = COUNT_W + 1;
   localparam int EXT_W       = CLUSTER_W + 1;

   localparam logic [EXT_W-1:0]     DEPTH_EXT     = EXT_W'(TABLE_DEPTH);
   localparam logic [EXT_W-1:0]     LAST_IDX_EXT  = EXT_W'(TABLE_DEPTH - 1);
   localparam logic [COUNT_W-1:0]   COUNT_RESET   = 12'd4094;

   localparam logic [CLUSTER_W-1:0] END_MARK  = 16'hFFFF;
   localparam logic [CLUSTER_W-1:0] END_LOW   = 16'hFFF8;
   localparam logic [CLUSTER_W-1:0] FREE_MARK = 16'h0000;
   localparam logic [CLUSTER_W-1:0] FIRST_CLUSTER = 16'd2;

   localparam logic [1:0] FUNC_READ  = 2'd0;
   localparam logic [1:0] FUNC_WRITE = 2'd1;
   localparam logic [1:0] FUNC_ALLOC = 2'd2;
   localparam logic [1:0] FUNC_FREE  = 2'd3;

   localparam logic [1:0] RD_REQ  = 2'd0;
   localparam logic [1:0] RD_SCAN = 2'd1;
   localparam logic [1:0] RD_CUR  = 2'd2;

   localparam logic [1:0] WR_CLEAR = 2'd0;
   localparam logic [1:0] WR_REQ   = 2'd1;
   localparam logic [1:0] WR_END   = 2'd2;
   localparam logic [1:0] WR_FREE  = 2'd3;

   localparam logic [2:0] RES_READ  = 3'd0;
   localparam logic [2:0] RES_WRITE = 3'd1;
   localparam logic [2:0] RES_ALLOC = 3'd2;
   localparam logic [2:0] RES_FAIL  = 3'd3;
   localparam logic [2:0] RES_DONE  = 3'd4;

   typedef struct packed {
      logic [1:0]           func;
      logic [CLUSTER_W-1:0] cluster;
      logic [CLUSTER_W-1:0] entry_value;
   } fcct_req_type;

   typedef struct packed {
      logic [CLUSTER_W-1:0] result_value;
      logic                 ok;
   } fcct_rsp_type;

   typedef struct packed {
      logic       clear_inc;
      logic       load_req;
      logic [1:0] rd_sel;
      logic       wr_en;
      logic [1:0] wr_sel;
      logic       scan_init;
      logic       scan_inc;
      logic       free_init;
      logic       free_step;
      logic       free_adv;
      logic       res_load;
      logic [2:0] res_sel;
      logic       out_load;
   } fcct_cmd_type;

   typedef struct packed {
      logic       clear_last;
      logic [1:0] func;
      logic       req_in_table;
      logic       alloc_empty;
      logic       scan_hit;
      logic       scan_last;
      logic       start_low;
      logic       free_stop;
      logic       cur_in_table;
      logic       self_link;
      logic       rsp_free;
   } fcct_status_type;

endpackage

/* rtl/core/fcct_ram.sv */
module fcct_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/fcct_datapath.sv */
module fcct_datapath
   import fcct_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  fcct_req_type    req_data,
   output fcct_rsp_type    rsp_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  logic            csr_wr_en,
   input  logic [COUNT_W-1:0] csr_wr_data,
   input  fcct_cmd_type    cmd,
   output fcct_status_type status
);

   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]     clear_ff, clear_in;
   fcct_req_type         req_ff, req_in;
   logic [IDX_W-1:0]     scan_ff, scan_in;
   logic [CLUSTER_W-1:0] cur_ff, cur_in;
   logic [STEP_W-1:0]    steps_ff, steps_in;
   logic [CLUSTER_W-1:0] res_value_ff, res_value_in;
   logic                 res_ok_ff, res_ok_in;
   fcct_rsp_type         rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic                 ram_wr_en;
   logic [IDX_W-1:0]     ram_wr_addr, ram_rd_addr;
   logic [CLUSTER_W-1:0] ram_wr_data, ram_rd_data;
   logic [EXT_W-1:0]     alloc_sum, alloc_last;

   fcct_ram #(
      .WIDTH(CLUSTER_W),
      .DEPTH(TABLE_DEPTH)
   ) u_table (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   assign alloc_sum  = EXT_W'(count_ff) + EXT_W'(1);
   assign alloc_last = (alloc_sum > LAST_IDX_EXT) ? LAST_IDX_EXT : alloc_sum;

   always_comb begin
      case (cmd.rd_sel)
         RD_REQ:  ram_rd_addr = req_data.cluster[IDX_W-1:0];
         RD_SCAN: ram_rd_addr = scan_ff;
         RD_CUR:  ram_rd_addr = cur_ff[IDX_W-1:0];
         default: ram_rd_addr = req_data.cluster[IDX_W-1:0];
      endcase
   end

   always_comb begin
      ram_wr_en = cmd.wr_en;
      case (cmd.wr_sel)
         WR_CLEAR: begin
            ram_wr_addr = clear_ff;
            ram_wr_data = FREE_MARK;
         end
         WR_REQ: begin
            ram_wr_addr = req_ff.cluster[IDX_W-1:0];
            ram_wr_data = req_ff.entry_value;
         end
         WR_END: begin
            ram_wr_addr = scan_ff;
            ram_wr_data = END_MARK;
         end
         WR_FREE: begin
            ram_wr_addr = cur_ff[IDX_W-1:0];
            ram_wr_data = FREE_MARK;
         end
         default: begin
            ram_wr_addr = clear_ff;
            ram_wr_data = FREE_MARK;
         end
      endcase
   end

   always_comb begin
      count_in     = csr_wr_en ? csr_wr_data : count_ff;
      clear_in     = cmd.clear_inc ? clear_ff + IDX_W'(1) : clear_ff;
      req_in       = cmd.load_req ? req_data : req_ff;
      scan_in      = scan_ff;
      if (cmd.scan_init) begin
         scan_in = IDX_W'(2);
      end else if (cmd.scan_inc) begin
         scan_in = scan_ff + IDX_W'(1);
      end
      cur_in       = cur_ff;
      steps_in     = steps_ff;
      if (cmd.free_init) begin
         cur_in   = req_ff.cluster;
         steps_in = STEP_W'(count_ff) + STEP_W'(2);
      end else begin
         if (cmd.free_step) begin
            steps_in = steps_ff - STEP_W'(1);
         end
         if (cmd.free_adv) begin
            cur_in = ram_rd_data;
         end
      end
      res_value_in = res_value_ff;
      res_ok_in    = res_ok_ff;
      if (cmd.res_load) begin
         case (cmd.res_sel)
            RES_READ: begin
               res_value_in = status.req_in_table ? ram_rd_data : FREE_MARK;
               res_ok_in    = status.req_in_table;
            end
            RES_WRITE: begin
               res_value_in = FREE_MARK;
               res_ok_in    = status.req_in_table;
            end
            RES_ALLOC: begin
               res_value_in = CLUSTER_W'(scan_ff);
               res_ok_in    = 1'b1;
            end
            RES_DONE: begin
               res_value_in = FREE_MARK;
               res_ok_in    = 1'b1;
            end
            default: begin
               res_value_in = FREE_MARK;
               res_ok_in    = 1'b0;
            end
         endcase
      end
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_in.result_value = res_value_ff;
         rsp_in.ok           = res_ok_ff;
         rsp_valid_in        = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= COUNT_RESET;
         clear_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         clear_ff     <= clear_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      scan_ff      <= scan_in;
      cur_ff       <= cur_in;
      steps_ff     <= steps_in;
      res_value_ff <= res_value_in;
      res_ok_ff    <= res_ok_in;
      rsp_ff       <= rsp_in;
   end

   always_comb begin
      status.clear_last   = (clear_ff == IDX_W'(TABLE_DEPTH - 1));
      status.func         = req_ff.func;
      status.req_in_table = ({1'b0, req_ff.cluster} < DEPTH_EXT);
      status.alloc_empty  = (alloc_last < EXT_W'(2));
      status.scan_hit     = (ram_rd_data == FREE_MARK);
      status.scan_last    = (EXT_W'(scan_ff) == alloc_last);
      status.start_low    = (req_ff.cluster < FIRST_CLUSTER);
      status.free_stop    = (cur_ff < FIRST_CLUSTER) || (cur_ff >= END_LOW)
                            || (steps_ff == '0);
      status.cur_in_table = ({1'b0, cur_ff} < DEPTH_EXT);
      status.self_link    = (ram_rd_data == cur_ff);
      status.rsp_free     = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/core/fcct_ctrl.sv */
module fcct_ctrl
   import fcct_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  fcct_status_type status,
   output fcct_cmd_type    cmd
);

   localparam logic [2:0] S_CLEAR     = 3'd0;
   localparam logic [2:0] S_IDLE      = 3'd1;
   localparam logic [2:0] S_EXEC      = 3'd2;
   localparam logic [2:0] S_ALLOC_RD  = 3'd3;
   localparam logic [2:0] S_ALLOC_CHK = 3'd4;
   localparam logic [2:0] S_FREE_CHK  = 3'd5;
   localparam logic [2:0] S_FREE_WR   = 3'd6;
   localparam logic [2:0] S_OUT       = 3'd7;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.rd_sel  = RD_REQ;
      cmd.wr_sel  = WR_CLEAR;
      cmd.res_sel = RES_FAIL;
      req_ready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.wr_en     = 1'b1;
            cmd.clear_inc = 1'b1;
            if (status.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            case (status.func)
               FUNC_READ: begin
                  cmd.res_load = 1'b1;
                  cmd.res_sel  = RES_READ;
                  state_in     = S_OUT;
               end
               FUNC_WRITE: begin
                  cmd.wr_en    = status.req_in_table;
                  cmd.wr_sel   = WR_REQ;
                  cmd.res_load = 1'b1;
                  cmd.res_sel  = RES_WRITE;
                  state_in     = S_OUT;
               end
               FUNC_ALLOC: begin
                  if (status.alloc_empty) begin
                     cmd.res_load = 1'b1;
                     state_in     = S_OUT;
                  end else begin
                     cmd.scan_init = 1'b1;
                     state_in      = S_ALLOC_RD;
                  end
               end
               default: begin
                  if (status.start_low) begin
                     cmd.res_load = 1'b1;
                     state_in     = S_OUT;
                  end else begin
                     cmd.free_init = 1'b1;
                     state_in      = S_FREE_CHK;
                  end
               end
            endcase
         end
         S_ALLOC_RD: begin
            cmd.rd_sel = RD_SCAN;
            state_in   = S_ALLOC_CHK;
         end
         S_ALLOC_CHK: begin
            if (status.scan_hit) begin
               cmd.wr_en    = 1'b1;
               cmd.wr_sel   = WR_END;
               cmd.res_load = 1'b1;
               cmd.res_sel  = RES_ALLOC;
               state_in     = S_OUT;
            end else if (status.scan_last) begin
               cmd.res_load = 1'b1;
               state_in     = S_OUT;
            end else begin
               cmd.scan_inc = 1'b1;
               state_in     = S_ALLOC_RD;
            end
         end
         S_FREE_CHK: begin
            cmd.rd_sel = RD_CUR;
            if (status.free_stop) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = RES_DONE;
               state_in     = S_OUT;
            end else if (!status.cur_in_table) begin
               cmd.res_load = 1'b1;
               state_in     = S_OUT;
            end else begin
               cmd.free_step = 1'b1;
               state_in      = S_FREE_WR;
            end
         end
         S_FREE_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_FREE;
            if (status.self_link) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = RES_DONE;
               state_in     = S_OUT;
            end else begin
               cmd.free_adv = 1'b1;
               state_in     = S_FREE_CHK;
            end
         end
         S_OUT: begin
            if (status.rsp_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/core/fat16_cluster_chain_table_core.sv */
// Read and write: one item at a time, the result passing to the output register.
// Allocate: a RAM read state and a check state for each table entry scanned.
// Free chain: each link walked is read, then zeroed, in the table RAM;
// the walk also ends on a self-link, and a start below 2 is answered without a walk.
// A new item is taken while the previous result still waits in the output register.
// Synchronous reset; afterwards a clearing pass zeroes all 4096 entries,
// one per cycle, with req_ready low until the pass is done.
module fat16_cluster_chain_table_core
   import fcct_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  fcct_req_type       req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output fcct_rsp_type       rsp_data,
   input  logic               csr_wr_en,
   input  logic [COUNT_W-1:0] csr_wr_data
);

   fcct_cmd_type    cmd;
   fcct_status_type status;

   fcct_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .status   (status),
      .cmd      (cmd)
   );

   fcct_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .rsp_data   (rsp_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

/* rtl/core/fcct_checker.sv */
module fcct_checker
   import fcct_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input fcct_rsp_type       rsp_data
);

   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("ready or valid high right after reset");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item taken while one is at work");

   a_fail_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.ok |-> rsp_data.result_value == FREE_MARK)
      else $error("failed item carries a nonzero value");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result item changed");

endmodule

bind fat16_cluster_chain_table_core fcct_checker u_fcct_checker (.*);

/* dv/fat16_cluster_chain_table_core_test.sv */
module fat16_cluster_chain_table_core_test;
   timeunit 1ns;
   timeprecision 1ps;
   import fcct_pkg::*;

   localparam int CHAIN_END = 64;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   fcct_req_type       req_data;
   logic               rsp_valid;
   logic               rsp_ready;
   fcct_rsp_type       rsp_data;
   logic               csr_wr_en;
   logic [COUNT_W-1:0] csr_wr_data;

   logic [CLUSTER_W-1:0] fat_shadow [TABLE_DEPTH];
   logic [COUNT_W-1:0]   shadow_count;
   fcct_rsp_type         fat_rsp_due [$];
   fcct_rsp_type         last_due;
   int                   mismatches;
   int                   items_taken;
   int                   rsp_hold;
   bit                   no_idle;

   fat16_cluster_chain_table_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #100ms;
      $display("CHECKS FAILED");
      $finish;
   end

   // Table update and expected result for one accepted item.
   function automatic fcct_rsp_type fat_apply(fcct_req_type r);
      fcct_rsp_type         o;
      int                   last;
      int                   c;
      int                   cur;
      int                   steps;
      logic [CLUSTER_W-1:0] nxt;
      bit                   done;
      o = '0;
      case (r.func)
         FUNC_READ: begin
            if (r.cluster < TABLE_DEPTH) begin
               o.result_value = fat_shadow[r.cluster[IDX_W-1:0]];
               o.ok = 1'b1;
            end
         end
         FUNC_WRITE: begin
            if (r.cluster < TABLE_DEPTH) begin
               fat_shadow[r.cluster[IDX_W-1:0]] = r.entry_value;
               o.ok = 1'b1;
            end
         end
         FUNC_ALLOC: begin
            last = int'(shadow_count) + 1;
            if (last > TABLE_DEPTH - 1)
               last = TABLE_DEPTH - 1;
            for (c = 2; c <= last && !o.ok; c++) begin
               if (fat_shadow[IDX_W'(c)] == FREE_MARK) begin
                  fat_shadow[IDX_W'(c)] = END_MARK;
                  o.result_value = CLUSTER_W'(c);
                  o.ok = 1'b1;
               end
            end
         end
         default: begin
            if (r.cluster >= 2) begin
               o.ok = 1'b1;
               cur = int'(r.cluster);
               steps = int'(shadow_count) + 2;
               done = 1'b0;
               while (!done && cur >= 2 && cur < END_LOW && steps > 0) begin
                  steps--;
                  if (cur >= TABLE_DEPTH) begin
                     o.ok = 1'b0;
                     done = 1'b1;
                  end else begin
                     nxt = fat_shadow[IDX_W'(cur)];
                     fat_shadow[IDX_W'(cur)] = FREE_MARK;
                     if (nxt == cur)
                        done = 1'b1;
                     else
                        cur = int'(nxt);
                  end
               end
            end
         end
      endcase
      return o;
   endfunction

   function automatic int idle_gap();
      int r;
      if (no_idle)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 94)
         return $urandom_range(1, 3);
      return $urandom_range(12, 50);
   endfunction

   function automatic logic [CLUSTER_W-1:0] pick_cluster();
      case ($urandom_range(0, 3))
         0: return CLUSTER_W'($urandom_range(0, shadow_count + 3));
         1: return CLUSTER_W'($urandom_range(0, 16'hFFFF));
         2: return CLUSTER_W'($urandom_range(TABLE_DEPTH - 2, TABLE_DEPTH + 1));
         default: return CLUSTER_W'($urandom_range(16'hFFF6, 16'hFFFF));
      endcase
   endfunction

   task automatic flag_mismatch(string what);
      $display("MISMATCH at %0t ns: %s", $time, what);
      mismatches++;
   endtask

   task automatic push_fat_op(logic [1:0] f, logic [CLUSTER_W-1:0] cl,
                              logic [CLUSTER_W-1:0] v);
      fcct_req_type item;
      int           gap;
      item.func = f;
      item.cluster = cl;
      item.entry_value = v;
      gap = idle_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_ready !== 1'b1);
      last_due = fat_apply(item);
      fat_rsp_due.push_back(last_due);
      items_taken++;
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (fat_rsp_due.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_cluster_count(logic [COUNT_W-1:0] n);
      settle();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= n;
      shadow_count = n;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic test_entry_bounds();
      push_fat_op(FUNC_READ, 16'd0, 16'd0);
      push_fat_op(FUNC_READ, CLUSTER_W'(TABLE_DEPTH - 1), 16'd0);
      push_fat_op(FUNC_READ, CLUSTER_W'(TABLE_DEPTH), 16'd0);
      push_fat_op(FUNC_WRITE, 16'd0, 16'hFFFF);
      push_fat_op(FUNC_WRITE, 16'd1, 16'h0001);
      push_fat_op(FUNC_WRITE, CLUSTER_W'(TABLE_DEPTH - 1), 16'hAAAA);
      push_fat_op(FUNC_WRITE, CLUSTER_W'(TABLE_DEPTH), 16'h5555);
      push_fat_op(FUNC_WRITE, 16'hFFFF, 16'hFFFF);
      push_fat_op(FUNC_READ, 16'd0, 16'd0);
      push_fat_op(FUNC_READ, CLUSTER_W'(TABLE_DEPTH - 1), 16'd0);
   endtask

   task automatic test_alloc_and_free();
      repeat (3) push_fat_op(FUNC_ALLOC, 16'd0, 16'd0);
      push_fat_op(FUNC_WRITE, 16'd2, 16'd3);
      push_fat_op(FUNC_WRITE, 16'd3, 16'd4);
      push_fat_op(FUNC_FREE, 16'd2, 16'd0);
      push_fat_op(FUNC_READ, 16'd4, 16'd0);
      push_fat_op(FUNC_FREE, 16'd0, 16'd0);
      push_fat_op(FUNC_FREE, 16'd1, 16'd0);
      push_fat_op(FUNC_FREE, END_LOW, 16'd0);
      push_fat_op(FUNC_FREE, END_MARK, 16'd0);
      push_fat_op(FUNC_FREE, CLUSTER_W'(TABLE_DEPTH), 16'd0);
   endtask

   task automatic test_free_stops();
      // link off the end of the table
      push_fat_op(FUNC_WRITE, 16'd20, 16'hFFF7);
      push_fat_op(FUNC_FREE, 16'd20, 16'd0);
      // self-link
      push_fat_op(FUNC_WRITE, 16'd21, 16'd21);
      push_fat_op(FUNC_FREE, 16'd21, 16'd0);
      // link below the first data cluster
      push_fat_op(FUNC_WRITE, 16'd23, 16'd22);
      push_fat_op(FUNC_WRITE, 16'd22, 16'd1);
      push_fat_op(FUNC_FREE, 16'd23, 16'd0);
      push_fat_op(FUNC_READ, 16'd22, 16'd0);
      // two-entry loop
      push_fat_op(FUNC_WRITE, 16'd24, 16'd25);
      push_fat_op(FUNC_WRITE, 16'd25, 16'd24);
      push_fat_op(FUNC_FREE, 16'd24, 16'd0);
   endtask

   task automatic test_step_limit();
      set_cluster_count(12'd0);
      push_fat_op(FUNC_ALLOC, 16'd0, 16'd0);
      push_fat_op(FUNC_WRITE, 16'd30, 16'd31);
      push_fat_op(FUNC_WRITE, 16'd31, 16'd32);
      push_fat_op(FUNC_WRITE, 16'd32, END_MARK);
      push_fat_op(FUNC_FREE, 16'd30, 16'd0);
      push_fat_op(FUNC_READ, 16'd32, 16'd0);
      set_cluster_count(12'd3);
      repeat (4) push_fat_op(FUNC_ALLOC, 16'd0, 16'd0);
   endtask

   // One long chain from the first data cluster: a long failing scan and a full walk.
   task automatic test_long_chain();
      set_cluster_count(COUNT_W'(CHAIN_END - 2));
      no_idle = 1'b1;
      for (int c = 2; c < CHAIN_END - 1; c++)
         push_fat_op(FUNC_WRITE, CLUSTER_W'(c), CLUSTER_W'(c + 1));
      push_fat_op(FUNC_WRITE, CLUSTER_W'(CHAIN_END - 1), END_MARK);
      push_fat_op(FUNC_WRITE, CLUSTER_W'(CHAIN_END), FREE_MARK);
      no_idle = 1'b0;
      push_fat_op(FUNC_ALLOC, 16'd0, 16'd0);
      set_cluster_count(COUNT_W'(CHAIN_END - 1));
      push_fat_op(FUNC_ALLOC, 16'd0, 16'd0);
      push_fat_op(FUNC_ALLOC, 16'd0, 16'd0);
      push_fat_op(FUNC_FREE, 16'd2, 16'd0);
      push_fat_op(FUNC_FREE, CLUSTER_W'(CHAIN_END), 16'd0);
      push_fat_op(FUNC_READ, CLUSTER_W'(CHAIN_END - 1), 16'd0);
   endtask

   task automatic test_backpressure();
      set_cluster_count(12'd40);
      rsp_hold = 300;
      no_idle = 1'b1;
      repeat (40)
         push_fat_op($urandom_range(0, 1) ? FUNC_READ : FUNC_WRITE,
                     CLUSTER_W'($urandom_range(0, 63)),
                     CLUSTER_W'($urandom_range(0, 16'hFFFF)));
      no_idle = 1'b0;
      settle();
   endtask

   task automatic run_chain();
      logic [CLUSTER_W-1:0] links [$];
      logic [CLUSTER_W-1:0] tail;
      int                   n;
      n = $urandom_range(1, 6);
      repeat (n) begin
         push_fat_op(FUNC_ALLOC, CLUSTER_W'($urandom_range(0, 16'hFFFF)),
                     CLUSTER_W'($urandom_range(0, 16'hFFFF)));
         if (last_due.ok)
            links.push_back(last_due.result_value);
      end
      if (links.size() == 0) begin
         push_fat_op(FUNC_FREE, pick_cluster(), CLUSTER_W'($urandom_range(0, 16'hFFFF)));
         return;
      end
      for (int i = 0; i + 1 < links.size(); i++)
         push_fat_op(FUNC_WRITE, links[i], links[i + 1]);
      tail = links[links.size() - 1];
      case ($urandom_range(0, 5))
         0: ;
         1: push_fat_op(FUNC_WRITE, tail, CLUSTER_W'($urandom_range(END_LOW, END_MARK)));
         2: push_fat_op(FUNC_WRITE, tail, CLUSTER_W'($urandom_range(0, 1)));
         3: push_fat_op(FUNC_WRITE, tail, tail);
         4: push_fat_op(FUNC_WRITE, tail, links[0]);
         default: push_fat_op(FUNC_WRITE, tail,
                              CLUSTER_W'($urandom_range(TABLE_DEPTH, END_LOW - 1)));
      endcase
      if ($urandom_range(0, 2) == 0)
         push_fat_op(FUNC_READ, links[$urandom_range(0, links.size() - 1)], 16'd0);
      push_fat_op(FUNC_FREE,
                  links[($urandom_range(0, 3) == 0) ? $urandom_range(0, links.size() - 1) : 0],
                  CLUSTER_W'($urandom_range(0, 16'hFFFF)));
      if ($urandom_range(0, 1))
         push_fat_op(FUNC_READ, tail, 16'd0);
   endtask

   task automatic test_random_traffic();
      int counts [8] = '{0, 4094, 4095, 2, 0, 0, 4094, 0};
      int phase_start;
      counts[4] = $urandom_range(3, 80);
      counts[5] = $urandom_range(1, 4093);
      counts[7] = $urandom_range(3, 30);
      foreach (counts[p]) begin
         set_cluster_count(COUNT_W'(counts[p]));
         no_idle = ($urandom_range(0, 3) == 0);
         phase_start = items_taken;
         while (items_taken - phase_start < 45) begin
            if ($urandom_range(0, 9) < 7)
               run_chain();
            else
               push_fat_op(2'($urandom_range(0, 3)), pick_cluster(),
                           $urandom_range(0, 1)
                              ? CLUSTER_W'($urandom_range(0, 16'hFFFF))
                              : CLUSTER_W'($urandom_range(0, shadow_count + 3)));
         end
      end
      no_idle = 1'b0;
   endtask

   // result drain: random stalls plus the long hold-off on request
   initial begin
      int stall;
      stall = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold > 0) begin
            rsp_ready <= 1'b0;
            rsp_hold--;
         end else if (stall > 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else begin
            rsp_ready <= 1'b1;
            stall = idle_gap();
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      fcct_rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (fat_rsp_due.size() == 0) begin
            flag_mismatch($sformatf("unexpected item: value %h ok %b",
                                    rsp_data.result_value, rsp_data.ok));
         end else begin
            want = fat_rsp_due.pop_front();
            if (rsp_data.result_value !== want.result_value)
               flag_mismatch($sformatf("result_value %h, want %h",
                                       rsp_data.result_value, want.result_value));
            if (rsp_data.ok !== want.ok)
               flag_mismatch($sformatf("ok %b, want %b", rsp_data.ok, want.ok));
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      mismatches = 0;
      items_taken = 0;
      rsp_hold = 0;
      no_idle = 1'b0;
      shadow_count = COUNT_RESET;
      foreach (fat_shadow[i])
         fat_shadow[i] = FREE_MARK;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_entry_bounds();
      test_alloc_and_free();
      test_free_stops();
      test_step_limit();
      test_long_chain();
      test_backpressure();
      test_random_traffic();
      settle();

      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

/* fat16_cluster_chain_table_core.f */
rtl/core/fcct_pkg.sv
rtl/core/fcct_ram.sv
rtl/core/fcct_datapath.sv
rtl/core/fcct_ctrl.sv
rtl/core/fat16_cluster_chain_table_core.sv
rtl/core/fcct_checker.sv
dv/fat16_cluster_chain_table_core_test.sv
